// ----- rtl/ctht_pkg.sv -----
package ctht_pkg;

    localparam int POS_W  = 11;
    localparam int NEST_W = 8;

    localparam logic [POS_W-1:0]  MAX_LEN  = 11'd1024;
    localparam logic [NEST_W-1:0] NEST_MAX = 8'd255;

    // Number of mode transitions that may chain on a single byte.
    localparam int CHAIN_STEPS = 4;
    // Candidate results per byte: one per chained step, the open span at
    // the last byte, and the end-of-header event.
    localparam int CAND_N = CHAIN_STEPS + 2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] KIND_TYPE    = 2'd0;
    localparam logic [1:0] KIND_SUBTYPE = 2'd1;
    localparam logic [1:0] KIND_PARAM   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    typedef enum logic [3:0] {
        M_TYPE        = 4'd0,
        M_SUBTYPE     = 4'd1,
        M_AFTER_SUB   = 4'd2,
        M_PNAME       = 4'd3,
        M_AFTER_NAME  = 4'd4,
        M_VALUE       = 4'd5,
        M_POST_QUOTE  = 4'd6,
        M_SPACE       = 4'd7,
        M_QUOTED      = 4'd8,
        M_QESC        = 4'd9,
        M_COMMENT     = 4'd10,
        M_COMMENT_END = 4'd11
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        mode_t             resume;
        logic [POS_W-1:0]  seg;
        logic [POS_W-1:0]  pns;
        logic [POS_W-1:0]  pne;
        logic              name_present;
        logic              equals_seen;
        logic [NEST_W-1:0] open_cnt;
        logic [NEST_W-1:0] close_cnt;
        logic              type_nonzero;
    } tok_state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] param_start;
        logic [POS_W-1:0] param_end;
        logic [POS_W-1:0] span_start;
        logic [POS_W-1:0] span_end;
        logic             type_found;
        logic             overflow;
    } event_t;

    // All results caused by one request; two is set when ev1 is present.
    typedef struct packed {
        event_t ev0;
        event_t ev1;
        logic   two;
    } record_t;

    typedef struct packed {
        tok_state_t st;
        logic       done;
        logic       ev_valid;
        event_t     ev;
    } step_t;

    function automatic tok_state_t tok_reset();
        tok_state_t s;
        s.mode         = M_SPACE;
        s.resume       = M_TYPE;
        s.seg          = '0;
        s.pns          = '0;
        s.pne          = '0;
        s.name_present = 1'b0;
        s.equals_seen  = 1'b0;
        s.open_cnt     = '0;
        s.close_cnt    = '0;
        s.type_nonzero = 1'b0;
        return s;
    endfunction

    function automatic logic is_ws(logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic event_t make_event(logic [1:0] kind,
                                          logic [POS_W-1:0] ns,
                                          logic [POS_W-1:0] ne,
                                          logic [POS_W-1:0] ss,
                                          logic [POS_W-1:0] se);
        event_t e;
        e.kind        = kind;
        e.param_start = ns;
        e.param_end   = ne;
        e.span_start  = ss;
        e.span_end    = se;
        e.type_found  = 1'b0;
        e.overflow    = 1'b0;
        return e;
    endfunction

    function automatic logic param_ok(tok_state_t s);
        return s.name_present && (s.pne > s.pns);
    endfunction

    // One mode transition for byte b at offset p.
    function automatic step_t tok_step(tok_state_t s, logic [7:0] b, logic [POS_W-1:0] p);
        step_t             r;
        logic              ws;
        logic [NEST_W-1:0] close_inc;
        r.st       = s;
        r.done     = 1'b0;
        r.ev_valid = 1'b0;
        r.ev       = '0;
        ws         = is_ws(b);
        close_inc  = (s.close_cnt < NEST_MAX) ? s.close_cnt + 1'b1 : s.close_cnt;
        unique case (s.mode)
            M_TYPE:
            begin
                if (ws || (b == CH_SEMI))
                begin
                    r.ev_valid        = 1'b1;
                    r.ev              = make_event(KIND_TYPE, '0, '0, s.seg, p);
                    r.st.type_nonzero = p > s.seg;
                    r.st.mode         = M_AFTER_SUB;
                end
                else if (b == CH_SLASH)
                begin
                    r.ev_valid        = 1'b1;
                    r.ev              = make_event(KIND_TYPE, '0, '0, s.seg, p);
                    r.st.type_nonzero = p > s.seg;
                    r.st.mode         = M_SPACE;
                    r.st.resume       = M_SUBTYPE;
                    r.done            = 1'b1;
                end
                else
                begin
                    r.done = 1'b1;
                end
            end
            M_SUBTYPE:
            begin
                if (ws || (b == CH_SEMI))
                begin
                    r.ev_valid = 1'b1;
                    r.ev       = make_event(KIND_SUBTYPE, '0, '0, s.seg, p);
                    r.st.mode  = M_AFTER_SUB;
                end
                else
                begin
                    r.done = 1'b1;
                end
            end
            M_AFTER_SUB:
            begin
                if (ws || (b == CH_SEMI))
                begin
                    r.done = 1'b1;
                end
                else
                begin
                    r.st.seg          = p;
                    r.st.name_present = 1'b0;
                    r.st.equals_seen  = 1'b0;
                    if (b == CH_LPAR)
                    begin
                        r.st.open_cnt  = NEST_W'(1);
                        r.st.close_cnt = '0;
                        r.st.mode      = M_COMMENT;
                        r.st.resume    = M_PNAME;
                        r.done         = 1'b1;
                    end
                    else
                    begin
                        r.st.mode = M_PNAME;
                    end
                end
            end
            M_PNAME:
            begin
                if (b == CH_EQ)
                begin
                    r.st.pns          = s.seg;
                    r.st.pne          = p;
                    r.st.name_present = 1'b1;
                    r.st.mode         = M_AFTER_NAME;
                    r.st.equals_seen  = 1'b1;
                    r.done            = 1'b1;
                end
                else if (ws)
                begin
                    r.st.pns          = s.seg;
                    r.st.pne          = p;
                    r.st.name_present = 1'b1;
                    r.st.mode         = M_AFTER_NAME;
                end
                else
                begin
                    r.done = 1'b1;
                end
            end
            M_AFTER_NAME:
            begin
                if (ws)
                begin
                    r.done = 1'b1;
                end
                else if (b == CH_EQ)
                begin
                    if (s.equals_seen)
                    begin
                        r.st.seg         = p;
                        r.st.equals_seen = 1'b0;
                        r.st.mode        = M_VALUE;
                    end
                    else
                    begin
                        r.st.equals_seen = 1'b1;
                    end
                    r.done = 1'b1;
                end
                else
                begin
                    r.st.seg = p;
                    if (s.equals_seen)
                    begin
                        r.st.mode = M_VALUE;
                    end
                    else
                    begin
                        r.st.mode         = M_PNAME;
                        r.st.name_present = 1'b0;
                    end
                end
            end
            M_VALUE:
            begin
                if (b == CH_QUOTE)
                begin
                    r.st.seg    = (p < MAX_LEN) ? p + 1'b1 : MAX_LEN;
                    r.st.mode   = M_QUOTED;
                    r.st.resume = M_POST_QUOTE;
                    r.done      = 1'b1;
                end
                else if (ws)
                begin
                    r.ev_valid        = param_ok(s);
                    r.ev              = make_event(KIND_PARAM, s.pns, s.pne, s.seg, p);
                    r.st.mode         = M_SPACE;
                    r.st.resume       = M_PNAME;
                    r.st.name_present = 1'b0;
                end
                else if (b == CH_LPAR)
                begin
                    r.ev_valid        = param_ok(s);
                    r.ev              = make_event(KIND_PARAM, s.pns, s.pne, s.seg, p);
                    r.st.open_cnt     = NEST_W'(1);
                    r.st.close_cnt    = '0;
                    r.st.mode         = M_COMMENT;
                    r.st.resume       = M_PNAME;
                    r.st.name_present = 1'b0;
                    r.done            = 1'b1;
                end
                else if (b == CH_SEMI)
                begin
                    r.ev_valid        = param_ok(s);
                    r.ev              = make_event(KIND_PARAM, s.pns, s.pne, s.seg, p);
                    r.st.mode         = M_SPACE;
                    r.st.resume       = M_PNAME;
                    r.st.name_present = 1'b0;
                    r.done            = 1'b1;
                end
                else
                begin
                    r.done = 1'b1;
                end
            end
            M_QUOTED:
            begin
                if (b == CH_BSL)
                begin
                    r.st.mode = M_QESC;
                end
                else if (b == CH_QUOTE)
                begin
                    r.ev_valid = param_ok(s);
                    r.ev       = make_event(KIND_PARAM, s.pns, s.pne, s.seg, p);
                    r.st.mode  = M_POST_QUOTE;
                end
                r.done = 1'b1;
            end
            M_QESC:
            begin
                r.st.mode = M_QUOTED;
                r.done    = 1'b1;
            end
            M_POST_QUOTE:
            begin
                if (b == CH_SEMI)
                begin
                    r.st.mode         = M_SPACE;
                    r.st.resume       = M_PNAME;
                    r.st.name_present = 1'b0;
                    r.done            = 1'b1;
                end
                else if (ws)
                begin
                    r.st.mode         = M_SPACE;
                    r.st.resume       = M_PNAME;
                    r.st.name_present = 1'b0;
                end
                else if (b == CH_LPAR)
                begin
                    r.st.open_cnt     = NEST_W'(1);
                    r.st.close_cnt    = '0;
                    r.st.mode         = M_COMMENT;
                    r.st.resume       = M_PNAME;
                    r.st.name_present = 1'b0;
                    r.done            = 1'b1;
                end
                else
                begin
                    r.st.mode         = M_PNAME;
                    r.st.resume       = M_PNAME;
                    r.st.name_present = 1'b0;
                    r.st.seg          = p;
                end
            end
            M_COMMENT:
            begin
                if (b == CH_LPAR)
                begin
                    if (s.open_cnt < NEST_MAX)
                    begin
                        r.st.open_cnt = s.open_cnt + 1'b1;
                    end
                end
                else if (b == CH_RPAR)
                begin
                    r.st.close_cnt = close_inc;
                    if (close_inc == s.open_cnt)
                    begin
                        r.st.mode = M_COMMENT_END;
                    end
                end
                r.done = 1'b1;
            end
            M_COMMENT_END:
            begin
                if (ws)
                begin
                    r.st.mode = M_SPACE;
                end
                else
                begin
                    r.st.seg  = p;
                    r.st.mode = s.resume;
                end
            end
            M_SPACE:
            begin
                if (ws)
                begin
                    r.done = 1'b1;
                end
                else if (b == CH_LPAR)
                begin
                    r.st.open_cnt  = NEST_W'(1);
                    r.st.close_cnt = '0;
                    r.st.mode      = M_COMMENT;
                    r.done         = 1'b1;
                end
                else
                begin
                    r.st.seg  = p;
                    r.st.mode = s.resume;
                end
            end
            default:
            begin
                r.st.mode = M_SPACE;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ctht_front.sv -----
module ctht_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_fire,
    input  logic [7:0]        byte_req,
    input  logic              last,
    output logic              push,
    output ctht_pkg::record_t push_rec
);
    import ctht_pkg::*;

    tok_state_t       st_reg;
    tok_state_t       st_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             ovf_cur;

    event_t           cand [CAND_N];
    logic [CAND_N-1:0] cand_valid;

    // Next state: the mode transitions of one byte chain through copies of
    // the step logic until one of them consumes the byte.
    always_comb
    begin
        step_t            sr;
        tok_state_t       s;
        logic             done_acc;
        logic [POS_W-1:0] pos_inc;
        s        = st_reg;
        done_acc = 1'b0;
        pos_inc  = (pos_reg < MAX_LEN) ? pos_reg + 1'b1 : MAX_LEN;
        ovf_cur  = ovf_reg | (pos_reg == MAX_LEN);
        for (int i = 0; i < CHAIN_STEPS; i++)
        begin
            sr            = tok_step(s, byte_req, pos_reg);
            cand[i]       = sr.ev;
            cand_valid[i] = 1'b0;
            if (!done_acc)
            begin
                s             = sr.st;
                cand_valid[i] = sr.ev_valid;
                done_acc      = sr.done;
            end
        end

        cand[CHAIN_STEPS]       = '0;
        cand_valid[CHAIN_STEPS] = 1'b0;
        if (last)
        begin
            if (s.mode == M_TYPE)
            begin
                cand[CHAIN_STEPS]       = make_event(KIND_TYPE, '0, '0, s.seg, pos_inc);
                cand_valid[CHAIN_STEPS] = 1'b1;
                s.type_nonzero          = pos_inc > s.seg;
            end
            else if (s.mode == M_SUBTYPE)
            begin
                cand[CHAIN_STEPS]       = make_event(KIND_SUBTYPE, '0, '0, s.seg, pos_inc);
                cand_valid[CHAIN_STEPS] = 1'b1;
            end
            else if (s.mode == M_VALUE)
            begin
                cand[CHAIN_STEPS]       = make_event(KIND_PARAM, s.pns, s.pne, s.seg, pos_inc);
                cand_valid[CHAIN_STEPS] = param_ok(s);
            end
        end

        cand[CHAIN_STEPS+1]            = make_event(KIND_END, '0, '0, '0, '0);
        cand[CHAIN_STEPS+1].type_found = s.type_nonzero;
        cand_valid[CHAIN_STEPS+1]      = last;

        st_next  = last ? tok_reset() : s;
        pos_next = last ? '0 : pos_inc;
        ovf_next = last ? 1'b0 : ovf_cur;
    end

    // Outputs: pack the results of this byte, in order, into one record.
    always_comb
    begin
        logic [1:0] n;
        event_t     slot0;
        event_t     slot1;
        n     = 2'd0;
        slot0 = '0;
        slot1 = '0;
        for (int i = 0; i < CAND_N; i++)
        begin
            if (cand_valid[i] && (n < 2'd2))
            begin
                if (n == 2'd0)
                begin
                    slot0 = cand[i];
                end
                else
                begin
                    slot1 = cand[i];
                end
                n = n + 2'd1;
            end
        end
        slot0.overflow = ovf_cur;
        slot1.overflow = ovf_cur;
        push_rec.ev0   = slot0;
        push_rec.ev1   = slot1;
        push_rec.two   = (n == 2'd2);
        push           = req_fire && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= tok_reset();
            pos_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            st_reg  <= st_next;
            pos_reg <= pos_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// ----- rtl/ctht_queue.sv -----
module ctht_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ctht_pkg::record_t push_rec,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output ctht_pkg::record_t head_rec
);
    import ctht_pkg::*;

    localparam logic [QPTR_W-1:0] QPTR_LAST  = QPTR_W'(QDEPTH - 1);
    localparam logic [QPTR_W:0]   QCNT_FULL  = (QPTR_W + 1)'(QDEPTH);

    record_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg;
    logic [QPTR_W:0]   cnt_next;

    assign full       = (cnt_reg == QCNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ----- rtl/ctht_back.sv -----
module ctht_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  ctht_pkg::record_t            head_rec,
    input  logic                         res_stall,
    output logic                         pop,
    output logic                         res_valid,
    output logic [1:0]                   kind,
    output logic [ctht_pkg::POS_W-1:0]   param_start,
    output logic [ctht_pkg::POS_W-1:0]   param_end,
    output logic [ctht_pkg::POS_W-1:0]   span_start,
    output logic [ctht_pkg::POS_W-1:0]   span_end,
    output logic                         type_found,
    output logic                         overflow,
    output logic                         end_of_run
);
    import ctht_pkg::*;

    // Set while the second result of the head record is on the port.
    logic   sub_reg;
    logic   sub_next;
    event_t cur;
    logic   fire;

    assign cur         = sub_reg ? head_rec.ev1 : head_rec.ev0;
    assign res_valid   = head_valid;
    assign kind        = cur.kind;
    assign param_start = cur.param_start;
    assign param_end   = cur.param_end;
    assign span_start  = cur.span_start;
    assign span_end    = cur.span_end;
    assign type_found  = cur.type_found;
    assign overflow    = cur.overflow;
    assign end_of_run  = sub_reg || !head_rec.two;
    assign fire        = head_valid && !res_stall;
    assign pop         = fire && end_of_run;

    always_comb
    begin
        sub_next = sub_reg;
        if (fire)
        begin
            sub_next = !end_of_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

endmodule

// ----- rtl/content_type_header_tokenizer.sv -----
// Content-Type header tokenizer. Header bytes enter one per cycle on the
// request channel, the final byte of each header marked by last; a request is
// taken whenever req_valid is high and req_stall is low. Each byte is
// classified in the cycle it is taken, and the results it causes (type span,
// subtype span, parameter offsets, and at the last byte the open span plus
// an end event) are written as one record into a four-entry queue. Results
// leave one per cycle while res_stall is low, the earliest in the cycle after the
// byte was taken. A byte causes zero, one or two results; the two-result case (only
// at the end of a header) puts both on the result port in turn. req_stall is high
// while the queue holds four records, which happens when res_stall holds
// results back or when two-result bytes arrive faster than the port drains
// them. After the last byte all offsets restart at zero for the next header.
module content_type_header_tokenizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [7:0]                   byte_req,
    input  logic                         last,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [1:0]                   kind,
    output logic [ctht_pkg::POS_W-1:0]   param_start,
    output logic [ctht_pkg::POS_W-1:0]   param_end,
    output logic [ctht_pkg::POS_W-1:0]   span_start,
    output logic [ctht_pkg::POS_W-1:0]   span_end,
    output logic                         type_found,
    output logic                         overflow,
    output logic                         end_of_run
);
    import ctht_pkg::*;

    logic    q_full;
    logic    req_fire;
    logic    push;
    record_t push_rec;
    logic    pop;
    logic    head_valid;
    record_t head_rec;

    assign req_stall = q_full;
    assign req_fire  = req_valid && !q_full;

    ctht_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .byte_req (byte_req),
        .last     (last),
        .push     (push),
        .push_rec (push_rec)
    );

    ctht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    ctht_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_rec    (head_rec),
        .res_stall   (res_stall),
        .pop         (pop),
        .res_valid   (res_valid),
        .kind        (kind),
        .param_start (param_start),
        .param_end   (param_end),
        .span_start  (span_start),
        .span_end    (span_end),
        .type_found  (type_found),
        .overflow    (overflow),
        .end_of_run  (end_of_run)
    );

endmodule

// ----- rtl/ctht_checker.sv -----
module ctht_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input logic                       last,
    input logic                       res_valid,
    input logic                       res_stall,
    input logic [1:0]                 kind,
    input logic [ctht_pkg::POS_W-1:0] span_start,
    input logic [ctht_pkg::POS_W-1:0] span_end,
    input logic                       end_of_run
);
    import ctht_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(kind) && $stable(span_start)
            && $stable(span_end) && $stable(end_of_run))
        else $error("result changed while stalled");

    // Only the end event ever follows another result of the same byte.
    a_second_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !end_of_run |=> res_valid && (kind == KIND_END)
            && end_of_run)
        else $error("second result of a byte is not the end event");

    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid)
        else $error("request stalled with no result pending");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && last |=> res_valid)
        else $error("last byte taken but no result pending");

endmodule

bind content_type_header_tokenizer ctht_checker u_ctht_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .last       (last),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .kind       (kind),
    .span_start (span_start),
    .span_end   (span_end),
    .end_of_run (end_of_run)
);

// ----- tb/tb_content_type_header_tokenizer.sv -----
`timescale 1ns / 100ps

module tb_content_type_header_tokenizer;
    import ctht_pkg::*;

    localparam int   IDLE_LIMIT  = 3000;
    localparam int   PHASE_ITEMS = 225;
    localparam int   LONG_LEN    = 1100;
    localparam logic PREDICTED   = 1'b0;
    localparam logic TYPED       = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] param_start;
        logic [POS_W-1:0] param_end;
        logic [POS_W-1:0] span_start;
        logic [POS_W-1:0] span_end;
        logic             type_found;
        logic             overflow;
        logic             end_of_run;
    } token_event_t;

    typedef struct packed {
        logic [7:0]   b;
        logic         l;
        logic         typed;
        logic [1:0]   n_events;
        token_event_t ev;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    logic [7:0]       byte_req = '0;
    logic             last = 1'b0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    logic [1:0]       kind;
    logic [POS_W-1:0] param_start;
    logic [POS_W-1:0] param_end;
    logic [POS_W-1:0] span_start;
    logic [POS_W-1:0] span_end;
    logic             type_found;
    logic             overflow;
    logic             end_of_run;

    content_type_header_tokenizer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .byte_req    (byte_req),
        .last        (last),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .kind        (kind),
        .param_start (param_start),
        .param_end   (param_end),
        .span_start  (span_start),
        .span_end    (span_end),
        .type_found  (type_found),
        .overflow    (overflow),
        .end_of_run  (end_of_run)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Tokenizer copy kept by the testbench.
    mode_t             st_mode;
    mode_t             st_resume;
    logic [POS_W-1:0]  hdr_pos;
    logic [POS_W-1:0]  seg_begin;
    logic [POS_W-1:0]  pname_begin;
    logic [POS_W-1:0]  pname_stop;
    logic              have_name;
    logic              saw_equals;
    logic [NEST_W-1:0] lpar_cnt;
    logic [NEST_W-1:0] rpar_cnt;
    logic              type_nonempty;
    logic              hdr_overflow;

    token_event_t byte_events [0:1];
    int           byte_event_cnt;
    token_event_t pending_events [$];
    token_event_t got_exp;
    dir_row_t     dir_rows [$];
    logic [7:0]   hdr_bytes [$];

    int mismatch_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    function automatic logic is_blank(logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    task automatic clear_tokenizer();
        st_mode       = M_SPACE;
        st_resume     = M_TYPE;
        hdr_pos       = '0;
        seg_begin     = '0;
        pname_begin   = '0;
        pname_stop    = '0;
        have_name     = 1'b0;
        saw_equals    = 1'b0;
        lpar_cnt      = '0;
        rpar_cnt      = '0;
        type_nonempty = 1'b0;
        hdr_overflow  = 1'b0;
    endtask

    task automatic add_event(logic [1:0] k, logic [POS_W-1:0] ns, logic [POS_W-1:0] ne,
                             logic [POS_W-1:0] ss, logic [POS_W-1:0] se, logic tf);
        token_event_t ev;
        if (byte_event_cnt < 2)
        begin
            ev.kind        = k;
            ev.param_start = ns;
            ev.param_end   = ne;
            ev.span_start  = ss;
            ev.span_end    = se;
            ev.type_found  = tf;
            ev.overflow    = hdr_overflow;
            ev.end_of_run  = 1'b0;
            byte_events[byte_event_cnt] = ev;
            byte_event_cnt++;
        end
    endtask

    task automatic note_type(logic [POS_W-1:0] span_stop);
        type_nonempty = span_stop > seg_begin;
        add_event(KIND_TYPE, '0, '0, seg_begin, span_stop, 1'b0);
    endtask

    // A parameter is reported only when its name is present and not empty.
    task automatic note_param(logic [POS_W-1:0] vs, logic [POS_W-1:0] ve);
        if (have_name && (pname_stop > pname_begin))
        begin
            add_event(KIND_PARAM, pname_begin, pname_stop, vs, ve, 1'b0);
        end
    endtask

    task automatic start_comment();
        lpar_cnt = NEST_W'(1);
        rpar_cnt = '0;
        st_mode  = M_COMMENT;
    endtask

    task automatic to_next_param(mode_t m);
        st_mode   = m;
        st_resume = M_PNAME;
        have_name = 1'b0;
    endtask

    task automatic take_name(logic [POS_W-1:0] p);
        pname_begin = seg_begin;
        pname_stop  = p;
        have_name   = 1'b1;
        st_mode     = M_AFTER_NAME;
    endtask

    // Works out the results that one header byte causes and advances the state.
    task automatic tokenize_byte(logic [7:0] b, logic l);
        logic [POS_W-1:0] p;
        logic             done;
        int               guard;
        p = hdr_pos;
        byte_event_cnt = 0;
        done = 1'b0;
        if (hdr_pos < MAX_LEN)
            hdr_pos = hdr_pos + 1'b1;
        else
            hdr_overflow = 1'b1;
        for (guard = 0; !done && (guard < 16); guard++)
        begin
            case (st_mode)
                M_TYPE:
                begin
                    if (is_blank(b) || (b == CH_SEMI))
                    begin
                        note_type(p);
                        st_mode = M_AFTER_SUB;
                    end
                    else if (b == CH_SLASH)
                    begin
                        note_type(p);
                        st_mode   = M_SPACE;
                        st_resume = M_SUBTYPE;
                        done      = 1'b1;
                    end
                    else
                        done = 1'b1;
                end
                M_SUBTYPE:
                begin
                    if (is_blank(b) || (b == CH_SEMI))
                    begin
                        add_event(KIND_SUBTYPE, '0, '0, seg_begin, p, 1'b0);
                        st_mode = M_AFTER_SUB;
                    end
                    else
                        done = 1'b1;
                end
                M_AFTER_SUB:
                begin
                    if (is_blank(b) || (b == CH_SEMI))
                        done = 1'b1;
                    else
                    begin
                        seg_begin  = p;
                        have_name  = 1'b0;
                        saw_equals = 1'b0;
                        if (b == CH_LPAR)
                        begin
                            start_comment();
                            st_resume = M_PNAME;
                            done      = 1'b1;
                        end
                        else
                            st_mode = M_PNAME;
                    end
                end
                M_PNAME:
                begin
                    if (b == CH_EQ)
                    begin
                        take_name(p);
                        saw_equals = 1'b1;
                        done       = 1'b1;
                    end
                    else if (is_blank(b))
                        take_name(p);
                    else
                        done = 1'b1;
                end
                M_AFTER_NAME:
                begin
                    if (is_blank(b))
                        done = 1'b1;
                    else if (b == CH_EQ)
                    begin
                        if (saw_equals)
                        begin
                            seg_begin  = p;
                            saw_equals = 1'b0;
                            st_mode    = M_VALUE;
                        end
                        else
                            saw_equals = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        seg_begin = p;
                        if (saw_equals)
                            st_mode = M_VALUE;
                        else
                        begin
                            st_mode   = M_PNAME;
                            have_name = 1'b0;
                        end
                    end
                end
                M_VALUE:
                begin
                    if (b == CH_QUOTE)
                    begin
                        seg_begin = (p < MAX_LEN) ? p + 1'b1 : MAX_LEN;
                        st_mode   = M_QUOTED;
                        st_resume = M_POST_QUOTE;
                        done      = 1'b1;
                    end
                    else if (is_blank(b))
                    begin
                        note_param(seg_begin, p);
                        to_next_param(M_SPACE);
                    end
                    else if (b == CH_LPAR)
                    begin
                        note_param(seg_begin, p);
                        start_comment();
                        st_resume = M_PNAME;
                        have_name = 1'b0;
                        done      = 1'b1;
                    end
                    else if (b == CH_SEMI)
                    begin
                        note_param(seg_begin, p);
                        to_next_param(M_SPACE);
                        done = 1'b1;
                    end
                    else
                        done = 1'b1;
                end
                M_QUOTED:
                begin
                    if (b == CH_BSL)
                        st_mode = M_QESC;
                    else if (b == CH_QUOTE)
                    begin
                        note_param(seg_begin, p);
                        st_mode = M_POST_QUOTE;
                    end
                    done = 1'b1;
                end
                M_QESC:
                begin
                    st_mode = M_QUOTED;
                    done    = 1'b1;
                end
                M_POST_QUOTE:
                begin
                    if (b == CH_SEMI)
                    begin
                        to_next_param(M_SPACE);
                        done = 1'b1;
                    end
                    else if (is_blank(b))
                        to_next_param(M_SPACE);
                    else if (b == CH_LPAR)
                    begin
                        start_comment();
                        st_resume = M_PNAME;
                        have_name = 1'b0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        to_next_param(M_PNAME);
                        seg_begin = p;
                    end
                end
                M_COMMENT:
                begin
                    // Both counters saturate; the comment closes when they match.
                    if (b == CH_LPAR)
                    begin
                        if (lpar_cnt < NEST_MAX)
                            lpar_cnt = lpar_cnt + 1'b1;
                    end
                    else if (b == CH_RPAR)
                    begin
                        if (rpar_cnt < NEST_MAX)
                            rpar_cnt = rpar_cnt + 1'b1;
                        if (rpar_cnt == lpar_cnt)
                            st_mode = M_COMMENT_END;
                    end
                    done = 1'b1;
                end
                M_COMMENT_END:
                begin
                    if (is_blank(b))
                        st_mode = M_SPACE;
                    else
                    begin
                        seg_begin = p;
                        st_mode   = st_resume;
                    end
                end
                M_SPACE:
                begin
                    if (is_blank(b))
                        done = 1'b1;
                    else if (b == CH_LPAR)
                    begin
                        start_comment();
                        done = 1'b1;
                    end
                    else
                    begin
                        seg_begin = p;
                        st_mode   = st_resume;
                    end
                end
                default:
                    st_mode = M_SPACE;
            endcase
        end
        if (l)
        begin
            if (st_mode == M_TYPE)
                note_type(hdr_pos);
            else if (st_mode == M_SUBTYPE)
                add_event(KIND_SUBTYPE, '0, '0, seg_begin, hdr_pos, 1'b0);
            else if (st_mode == M_VALUE)
                note_param(seg_begin, hdr_pos);
            add_event(KIND_END, '0, '0, '0, '0, type_nonempty);
            clear_tokenizer();
        end
        if (byte_event_cnt > 0)
            byte_events[byte_event_cnt - 1].end_of_run = 1'b1;
    endtask

    task automatic add_row(logic [7:0] b, logic l, logic typed, logic [1:0] n,
                           logic [1:0] k, logic [POS_W-1:0] ss, logic [POS_W-1:0] se,
                           logic tf);
        dir_row_t row;
        row.b             = b;
        row.l             = l;
        row.typed         = typed;
        row.n_events      = n;
        row.ev            = '0;
        row.ev.kind       = k;
        row.ev.span_start = ss;
        row.ev.span_end   = se;
        row.ev.type_found = tf;
        row.ev.end_of_run = 1'b1;
        dir_rows.push_back(row);
    endtask

    // Queues the expected results of one request, then offers it until taken.
    task automatic send_byte(logic [7:0] b, logic l, logic typed, logic [1:0] n_typed,
                             token_event_t typed_ev);
        int k;
        tokenize_byte(b, l);
        if (!typed)
        begin
            for (k = 0; k < byte_event_cnt; k++)
                pending_events.push_back(byte_events[k]);
        end
        else if (n_typed != 0)
            pending_events.push_back(typed_ev);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        byte_req  <= b;
        last      <= l;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic push_word(int len);
        repeat (len)
        begin
            if ($urandom_range(0, 15) == 0)
                hdr_bytes.push_back(8'($urandom_range(0, 255)));
            else
                hdr_bytes.push_back(8'($urandom_range(97, 122)));
        end
    endtask

    task automatic push_blanks(int maxn);
        int r;
        repeat ($urandom_range(0, maxn))
        begin
            r = $urandom_range(0, 6);
            hdr_bytes.push_back((r < 2) ? CH_SPACE : 8'(r + 7));
        end
    endtask

    task automatic push_comment();
        int depth;
        int c;
        depth = 1;
        hdr_bytes.push_back(CH_LPAR);
        repeat ($urandom_range(0, 6))
        begin
            c = $urandom_range(0, 3);
            if (c == 0)
            begin
                hdr_bytes.push_back(CH_LPAR);
                depth++;
            end
            else if ((c == 1) && (depth > 1))
            begin
                hdr_bytes.push_back(CH_RPAR);
                depth--;
            end
            else
                push_word(1);
        end
        repeat (depth)
            hdr_bytes.push_back(CH_RPAR);
    endtask

    task automatic push_value();
        if ($urandom_range(0, 2) == 0)
        begin
            hdr_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 5))
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    hdr_bytes.push_back(CH_BSL);
                    hdr_bytes.push_back(8'($urandom_range(0, 255)));
                end
                else
                    push_word(1);
            end
            hdr_bytes.push_back(CH_QUOTE);
        end
        else
            push_word($urandom_range(0, 6));
    endtask

    // Mostly well-formed headers with random content; some are cut short
    // (open quote or comment at the end) and some are pure noise. The long
    // form nests comments past the counter limit and runs past MAX_LEN.
    task automatic build_header(logic long_form);
        int r;
        int cut;
        hdr_bytes.delete();
        r = $urandom_range(0, 9);
        if (long_form)
        begin
            push_word(2);
            hdr_bytes.push_back(CH_SLASH);
            push_word(2);
            hdr_bytes.push_back(CH_SPACE);
            hdr_bytes.push_back(CH_LPAR);
            repeat (300)
                hdr_bytes.push_back(CH_LPAR);
            repeat (300)
                hdr_bytes.push_back(CH_RPAR);
            while (hdr_bytes.size() < LONG_LEN)
            begin
                push_blanks(1);
                hdr_bytes.push_back(CH_SEMI);
                push_word(3);
                hdr_bytes.push_back(CH_EQ);
                push_value();
            end
        end
        else if (r == 0)
        begin
            repeat ($urandom_range(1, 24))
                hdr_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            push_blanks(1);
            push_word($urandom_range(0, 6));
            if ($urandom_range(0, 5) != 0)
            begin
                hdr_bytes.push_back(CH_SLASH);
                push_word($urandom_range(0, 6));
            end
            repeat ($urandom_range(0, 3))
            begin
                push_blanks(2);
                if ($urandom_range(0, 3) == 0)
                    push_comment();
                hdr_bytes.push_back(CH_SEMI);
                push_blanks(2);
                push_word($urandom_range(0, 5));
                push_blanks(1);
                hdr_bytes.push_back(CH_EQ);
                if ($urandom_range(0, 7) == 0)
                    hdr_bytes.push_back(CH_EQ);
                push_blanks(1);
                push_value();
            end
            push_blanks(1);
            if ($urandom_range(0, 5) == 0)
                push_comment();
            if ((r == 1) && (hdr_bytes.size() > 1))
            begin
                cut = $urandom_range(1, hdr_bytes.size() - 1);
                while (hdr_bytes.size() > cut)
                    void'(hdr_bytes.pop_back());
            end
        end
        if (hdr_bytes.size() == 0)
            push_word(1);
    endtask

    function automatic void check_field(string fname, logic [POS_W-1:0] exp_v,
                                        logic [POS_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", fname, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $error("result with no request pending: kind %0d", kind);
                mismatch_count++;
            end
            else
            begin
                got_exp = pending_events.pop_front();
                check_field("kind", got_exp.kind, kind);
                check_field("param_start", got_exp.param_start, param_start);
                check_field("param_end", got_exp.param_end, param_end);
                check_field("span_start", got_exp.span_start, span_start);
                check_field("span_end", got_exp.span_end, span_end);
                check_field("type_found", got_exp.type_found, type_found);
                check_field("overflow", got_exp.overflow, overflow);
                check_field("end_of_run", got_exp.end_of_run, end_of_run);
            end
        end
        res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int       i;
        int       ph;
        int       sent;
        logic     long_form;
        logic     long_sent;
        dir_row_t row;
        clear_tokenizer();
        long_sent = 1'b0;

        // Header 1 walks every mode: type, subtype, nested comment, quoted
        // value with an escape, a double equals and a name with no value.
        add_row(CH_SLASH, 1'b0, TYPED, 2'd1, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_TAB,   1'b0, TYPED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(8'h78,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_SEMI,  1'b0, TYPED, 2'd1, KIND_SUBTYPE, 11'd2, 11'd3, 1'b0);
        add_row(CH_SPACE, 1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_LPAR,  1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_LPAR,  1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_RPAR,  1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_RPAR,  1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(8'h6E,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_EQ,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_QUOTE, 1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_BSL,   1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_QUOTE, 1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_QUOTE, 1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(8'hFF,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_EQ,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_EQ,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(8'h00,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_SEMI,  1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(8'h76,    1'b1, TYPED, 2'd1, KIND_END, 11'd0, 11'd0, 1'b0);
        // A one-byte header leaves the type open at the end.
        add_row(8'h61,    1'b1, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        // Quote left open with a backslash as the final byte.
        add_row(CH_SEMI,  1'b0, TYPED, 2'd1, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(8'h6B,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_EQ,    1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_QUOTE, 1'b0, PREDICTED, 2'd0, KIND_TYPE, 11'd0, 11'd0, 1'b0);
        add_row(CH_BSL,   1'b1, TYPED, 2'd1, KIND_END, 11'd0, 11'd0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_rows.size(); i++)
        begin
            row = dir_rows[i];
            send_byte(row.b, row.l, row.typed, row.n_events, row.ev);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 73; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                long_form = (ph == 3) && !long_sent;
                long_sent = long_sent | long_form;
                build_header(long_form);
                for (i = 0; i < hdr_bytes.size(); i++)
                begin
                    send_byte(hdr_bytes[i], i == hdr_bytes.size() - 1, PREDICTED, 2'd0, '0);
                end
                if (!long_form)
                    sent += hdr_bytes.size();
            end
            req_valid <= 1'b0;
            while (pending_events.size() != 0)
                @(posedge clk);
        end

        repeat (8) @(posedge clk);
        if ((mismatch_count == 0) && (pending_events.size() == 0))
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ctht_pkg.sv
rtl/ctht_front.sv
rtl/ctht_queue.sv
rtl/ctht_back.sv
rtl/content_type_header_tokenizer.sv
rtl/ctht_checker.sv
tb/tb_content_type_header_tokenizer.sv
